@@ design/bbc_pkg.sv @@
// Shared types, constants and bracket decoding for the bracket balance checker.
// No dependencies.
package bbc_pkg;

    localparam int unsigned STACK_DEPTH_DEF = 64;
    localparam logic [7:0]  CHUNK_RESET     = 8'd199;

    typedef enum logic [2:0] {
        ERR_NONE           = 3'd0,
        ERR_EXTRA_CLOSER   = 3'd1,
        ERR_MISMATCH       = 3'd2,
        ERR_MISSING_CLOSER = 3'd3,
        ERR_OVERFLOW       = 3'd4
    } t_err_code;

    typedef struct packed {
        logic       is_open;
        logic       is_close;
        logic [1:0] kind;
    } t_bkt;

    function automatic t_bkt bkt_decode(input logic [7:0] ch);
        t_bkt d;
        d = '0;
        case (ch)
            8'h3C: begin d.is_open  = 1'b1; d.kind = 2'd0; end // <
            8'h7B: begin d.is_open  = 1'b1; d.kind = 2'd1; end // {
            8'h28: begin d.is_open  = 1'b1; d.kind = 2'd2; end // (
            8'h5B: begin d.is_open  = 1'b1; d.kind = 2'd3; end // [
            8'h3E: begin d.is_close = 1'b1; d.kind = 2'd0; end // >
            8'h7D: begin d.is_close = 1'b1; d.kind = 2'd1; end // }
            8'h29: begin d.is_close = 1'b1; d.kind = 2'd2; end // )
            8'h5D: begin d.is_close = 1'b1; d.kind = 2'd3; end // ]
            default: d = '0;
        endcase
        return d;
    endfunction

endpackage

@@ design/bbc_ram.sv @@
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
module bbc_ram #(
    parameter int unsigned WIDTH = 2,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/bracket_balance_checker_top.sv @@
// Top level of the bracket balance checker: stream ports, line tracking and stack control.
// Depends on bbc_pkg and bbc_ram.
//
// One byte is taken per clock cycle and each transfer yields exactly one result, held in an
// output register; input is taken whenever that register is empty or being drained. The stack
// lives in a RAM with a registered read; the top entry is held in a register and the entry below
// it is read every cycle, so pushes and pops run back to back at one byte per cycle. The result
// is valid in the cycle after its input transfer. No clearing pass follows reset.
module bracket_balance_checker_top #(
    parameter int unsigned STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] char_byte
    input  logic        s_axis_tlast,  // line_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [2:0] error_code, [10:3] error_column, [15:11] zero
    output logic        m_axis_tlast   // line_done
);

    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned LW = $clog2(STACK_DEPTH + 1);

    logic [LW-1:0]      r_level, n_level;
    logic [7:0]         r_col, n_col;
    logic               r_skip, n_skip;
    logic [7:0]         r_chunk;
    logic [1:0]         r_top, n_top;
    logic               r_pop_last, n_pop_last;
    logic               r_out_valid;
    bbc_pkg::t_err_code r_out_err, n_err;
    logic [7:0]         r_out_col, n_ecol;
    logic               r_out_last, n_done;

    logic               w_acc;
    logic               w_push, w_pop;
    logic [1:0]         w_rd, w_eff_top;
    logic [8:0]         w_len;
    logic [7:0]         w_limit;
    bbc_pkg::t_bkt      w_bkt;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_bkt         = bbc_pkg::bkt_decode(s_axis_tdata);
    assign w_eff_top     = r_pop_last ? w_rd : r_top;
    assign w_len         = {1'b0, r_col} + 9'd1;
    assign w_limit       = (r_chunk == 8'd0) ? 8'd1 : r_chunk;

    bbc_ram #(
        .WIDTH (2),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_acc && w_push),
        .i_waddr (r_level[AW-1:0]),
        .i_wdata (w_bkt.kind),
        .i_raddr (AW'(r_level - LW'(2))),
        .o_rdata (w_rd)
    );

    always_comb begin
        n_level = r_level;
        n_skip  = r_skip;
        n_col   = r_col;
        n_err   = bbc_pkg::ERR_NONE;
        n_ecol  = 8'd0;
        w_push  = 1'b0;
        w_pop   = 1'b0;
        if (!r_skip) begin
            if (w_bkt.is_open) begin
                if (r_level == LW'(STACK_DEPTH)) begin
                    n_err = bbc_pkg::ERR_OVERFLOW;
                end else begin
                    w_push  = 1'b1;
                    n_level = r_level + LW'(1);
                end
            end else if (w_bkt.is_close) begin
                if (r_level == '0) begin
                    n_err = bbc_pkg::ERR_EXTRA_CLOSER;
                end else begin
                    w_pop   = 1'b1;
                    n_level = r_level - LW'(1);
                    if (w_eff_top != w_bkt.kind) begin
                        n_err = bbc_pkg::ERR_MISMATCH;
                    end
                end
            end
            if (n_err != bbc_pkg::ERR_NONE) begin
                n_ecol  = r_col;
                n_level = '0;
                n_skip  = 1'b1;
            end
        end
        n_done = s_axis_tlast || (w_len >= {1'b0, w_limit});
        if (n_done) begin
            if (n_err == bbc_pkg::ERR_NONE && n_level != '0) begin
                n_err  = bbc_pkg::ERR_MISSING_CLOSER;
                n_ecol = w_len[7:0];
            end
            n_level = '0;
            n_skip  = 1'b0;
            n_col   = 8'd0;
        end else begin
            n_col = w_len[7:0];
        end
    end

    always_comb begin
        n_top      = w_eff_top;
        n_pop_last = 1'b0;
        if (w_acc && w_push) begin
            n_top = w_bkt.kind;
        end
        if (w_acc && w_pop) begin
            n_pop_last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= '0;
            r_col       <= 8'd0;
            r_skip      <= 1'b0;
            r_chunk     <= bbc_pkg::CHUNK_RESET;
            r_pop_last  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pop_last <= n_pop_last;
            if (i_cfg_we) begin
                r_chunk <= i_cfg_wdata;
            end
            if (w_acc) begin
                r_level     <= n_level;
                r_col       <= n_col;
                r_skip      <= n_skip;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        if (w_acc) begin
            r_out_err  <= n_err;
            r_out_col  <= n_ecol;
            r_out_last <= n_done;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_col, r_out_err};
    assign m_axis_tlast  = r_out_last;

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LW'(STACK_DEPTH))
        else $error("stack level beyond depth");

    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && n_done) |=> (r_level == '0 && r_col == 8'd0 && !r_skip))
        else $error("line end left stack or column state");

    a_err_skips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !n_done && n_err != bbc_pkg::ERR_NONE) |=> (r_skip && r_level == '0))
        else $error("error did not start skipping");

    a_missing_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err == bbc_pkg::ERR_MISSING_CLOSER) |-> r_out_last)
        else $error("missing closers reported mid-line");

    a_skip_no_stack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip |-> (r_level == '0))
        else $error("stack not empty while skipping");

endmodule
